[rtl/lcfs_pkg.sv]
// Shared types and constants for the LED color fade stepper.
// Item structs, opcodes, queue entry and lane control structs; no dependencies.
`default_nettype none

package lcfs_pkg;

    localparam int FRAME_W = 31;

    localparam logic [1:0] OP_QUEUE   = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_SET     = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [FRAME_W-1:0] frame_in;
        logic [FRAME_W-1:0] now_frame;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       busy_res;
        logic       rejected;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [FRAME_W-1:0] frame;
    } t_step;

    typedef struct packed {
        logic start;
        logic load;
        logic finish;
        logic force_set;
        logic move;
    } t_lane_cmd;

    typedef struct packed {
        logic       busy;
        logic [7:0] color;
    } t_lane_stat;

endpackage

`default_nettype wire

[rtl/led_color_fade_stepper_core.sv]
// Top level of the LED color fade stepper: sequencer, step queue, three lanes, merge.
// Depends on lcfs_pkg, lcfs_queue and lcfs_lane.
//
//   channel  direction  handshake                    payload
//   input    in         i_in_valid / o_in_stall      i_in_item  (t_in_item)
//   output   out        o_out_valid / i_out_stall    o_out_item (t_out_item)
//
// A queue, clear or set item goes from the accepted input through S_OUT to the output
// register. An advance item loops in S_ADV, visits S_POP for each popped step, finishes
// a step in S_ADV itself and waits in S_MOVE for a partial move, whose lanes run the
// multiply and the 8-step carry divider (skipped when no carry is due), then S_OUT.
// Reset is synchronous; the next item is taken while a result waits in the output register.
// A stalled output holds its result; the sequencer waits only when a second result is ready.
`default_nettype none

module led_color_fade_stepper_core
    import lcfs_pkg::*;
#(
    parameter int STEP_QUEUE_DEPTH = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int CNT_W = $clog2(STEP_QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADV  = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic               r_active, n_active;
    logic [FRAME_W-1:0] r_now, n_now;
    logic [FRAME_W-1:0] r_end, n_end;
    logic [FRAME_W-1:0] r_span, n_span;
    logic [FRAME_W-1:0] r_target, n_target;
    logic               r_rej, n_rej;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item;
    logic               load_out;

    logic               q_clear, q_push, q_pop, q_full;
    t_step              q_wdata, q_rdata;
    logic [CNT_W-1:0]   q_count;

    t_lane_cmd          lane_cmd;
    t_lane_stat         lane_stat [3];
    logic [7:0]         lane_value [3];
    logic [7:0]         in_rgb [3];
    logic [7:0]         q_rgb [3];
    logic               any_busy;
    logic [FRAME_W-1:0] move_frames;

    assign in_rgb[0] = i_in_item.red_in;
    assign in_rgb[1] = i_in_item.green_in;
    assign in_rgb[2] = i_in_item.blue_in;
    assign q_rgb[0]  = q_rdata.red;
    assign q_rgb[1]  = q_rdata.green;
    assign q_rgb[2]  = q_rdata.blue;

    assign q_wdata.red   = i_in_item.red_in;
    assign q_wdata.green = i_in_item.green_in;
    assign q_wdata.blue  = i_in_item.blue_in;
    assign q_wdata.frame = i_in_item.frame_in;

    assign move_frames = r_target - r_now;
    assign any_busy    = lane_stat[0].busy | lane_stat[1].busy | lane_stat[2].busy;

    lcfs_queue #(
        .DEPTH (STEP_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (q_clear),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_count (q_count),
        .o_full  (q_full)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign lane_value[g] = (r_state == S_POP) ? q_rgb[g] : in_rgb[g];

        lcfs_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (lane_cmd),
            .i_value  (lane_value[g]),
            .i_frames (move_frames),
            .i_span   (r_span),
            .o_stat   (lane_stat[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_now    = r_now;
        n_end    = r_end;
        n_span   = r_span;
        n_target = r_target;
        n_rej    = r_rej;
        q_clear  = 1'b0;
        q_push   = 1'b0;
        q_pop    = 1'b0;
        lane_cmd = '0;
        load_out = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rej = 1'b0;
                    case (i_in_item.opcode)
                        OP_QUEUE: begin
                            if (!r_active) begin
                                n_active       = 1'b1;
                                n_now          = i_in_item.now_frame;
                                n_end          = '0;
                                n_span         = FRAME_W'(1);
                                q_clear        = 1'b1;
                                lane_cmd.start = 1'b1;
                            end
                            if (r_active && q_full) begin
                                n_rej = 1'b1;
                            end else begin
                                q_push = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        OP_ADVANCE: begin
                            n_target = i_in_item.frame_in;
                            n_state  = S_ADV;
                        end
                        default: begin
                            n_active = 1'b0;
                            q_clear  = 1'b1;
                            if (i_in_item.opcode == OP_SET) begin
                                lane_cmd.force_set = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_ADV: begin
                if (!r_active || !(r_now < r_target)) begin
                    n_state = S_OUT;
                end else if (r_now < r_end) begin
                    if (r_end > r_target) begin
                        lane_cmd.move = 1'b1;
                        n_now         = r_target;
                        n_state       = S_MOVE;
                    end else begin
                        lane_cmd.finish = 1'b1;
                        n_now           = r_end;
                    end
                end else if (q_count == '0) begin
                    n_active = 1'b0;
                    n_state  = S_OUT;
                end else begin
                    q_pop   = 1'b1;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_end         = q_rdata.frame;
                n_span        = q_rdata.frame - r_now;
                lane_cmd.load = 1'b1;
                n_state       = S_ADV;
            end
            S_MOVE: begin
                if (!any_busy) begin
                    n_state = S_ADV;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_now       <= '0;
            r_end       <= '0;
            r_span      <= FRAME_W'(1);
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_now       <= n_now;
            r_end       <= n_end;
            r_span      <= n_span;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        if (load_out) begin
            r_out_item.red_out   <= lane_stat[0].color;
            r_out_item.green_out <= lane_stat[1].color;
            r_out_item.blue_out  <= lane_stat[2].color;
            r_out_item.busy_res  <= r_active;
            r_out_item.rejected  <= r_rej;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_reject_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.rejected |-> o_out_item.busy_res)
        else $error("rejected item reported on an idle engine");

    a_lanes_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !any_busy)
        else $error("lane still moving while sequencer takes items");

    a_queue_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != '0 |-> r_active)
        else $error("steps pending on an idle engine");

endmodule

`default_nettype wire

[rtl/lcfs_queue.sv]
// Step queue: circular buffer of pending fade steps with registered read.
// Depends on lcfs_pkg for the t_step entry type.
`default_nettype none

module lcfs_queue
    import lcfs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_clear,
    input  wire logic                        i_push,
    input  wire t_step                       i_wdata,
    input  wire logic                        i_pop,
    output t_step                            o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]       o_count,
    output logic                             o_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    t_step            r_mem [DEPTH];
    t_step            r_rdata;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] head_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic [SUM_W-1:0] tail_sum, tail_wrap;
    logic [IDX_W-1:0] wr_idx;

    always_comb begin
        head_eff  = i_clear ? '0 : r_head;
        cnt_eff   = i_clear ? '0 : r_count;
        tail_sum  = SUM_W'(head_eff) + SUM_W'(cnt_eff);
        tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
        wr_idx    = tail_wrap[IDX_W-1:0];

        n_head  = r_head;
        n_count = r_count;
        if (i_clear) begin
            n_head  = '0;
            n_count = i_push ? CNT_W'(1) : '0;
        end else if (i_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop) begin
            n_head  = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[wr_idx] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;
    assign o_full  = (r_count == CNT_W'(DEPTH));

endmodule

`default_nettype wire

[rtl/lcfs_lane.sv]
// One color channel lane: channel value, delta, accumulator and carry divider.
// Depends on lcfs_pkg for frame width and lane control/status structs.
`default_nettype none

module lcfs_lane
    import lcfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_cmd          i_cmd,
    input  wire logic [7:0]         i_value,
    input  wire logic [FRAME_W-1:0] i_frames,
    input  wire logic [FRAME_W-1:0] i_span,
    output t_lane_stat              o_stat
);

    localparam int W    = FRAME_W + 10;
    localparam int ST_W = FRAME_W + 2;

    localparam logic [2:0] LN_IDLE = 3'd0;
    localparam logic [2:0] LN_MUL  = 3'd1;
    localparam logic [2:0] LN_SUM  = 3'd2;
    localparam logic [2:0] LN_CHK  = 3'd3;
    localparam logic [2:0] LN_DIV  = 3'd4;
    localparam logic [2:0] LN_DONE = 3'd5;

    logic [2:0]              r_st, n_st;
    logic [7:0]              r_color, n_color;
    logic [7:0]              r_goal, n_goal;
    logic signed [8:0]       r_delta, n_delta;
    logic signed [ST_W-1:0]  r_accum, n_accum;
    logic [FRAME_W-1:0]      r_frames, n_frames;
    logic signed [W-1:0]     r_prod, n_prod;
    logic signed [W-1:0]     r_work, n_work;
    logic [W-1:0]            r_rem, n_rem;
    logic [W-1:0]            r_dsor, n_dsor;
    logic [7:0]              r_q, n_q;
    logic [2:0]              r_cnt, n_cnt;
    logic                    r_neg, n_neg;
    logic signed [W-1:0]     span_w;
    logic signed [ST_W-1:0]  mag;

    always_comb begin
        span_w = $signed(W'(i_span));
        mag    = $signed(ST_W'(r_rem)) + ST_W'(1);

        n_st     = r_st;
        n_color  = r_color;
        n_goal   = r_goal;
        n_delta  = r_delta;
        n_accum  = r_accum;
        n_frames = r_frames;
        n_prod   = r_prod;
        n_work   = r_work;
        n_rem    = r_rem;
        n_dsor   = r_dsor;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_neg    = r_neg;

        case (r_st)
            LN_IDLE: begin
                if (i_cmd.start) begin
                    n_delta = '0;
                    n_accum = '0;
                end
                if (i_cmd.load) begin
                    n_goal  = i_value;
                    n_delta = $signed({1'b0, i_value}) - $signed({1'b0, r_color});
                    n_accum = '0;
                end
                if (i_cmd.finish) begin
                    n_color = r_goal;
                end
                if (i_cmd.force_set) begin
                    n_color = i_value;
                end
                if (i_cmd.move) begin
                    n_frames = i_frames;
                    n_st     = LN_MUL;
                end
            end
            LN_MUL: begin
                n_prod = $signed({1'b0, r_frames}) * r_delta;
                n_st   = LN_SUM;
            end
            LN_SUM: begin
                n_work = W'(r_accum) + r_prod;
                n_st   = LN_CHK;
            end
            LN_CHK: begin
                n_dsor = W'(i_span) << 7;
                n_q    = '0;
                n_cnt  = 3'd7;
                if (r_work > span_w) begin
                    n_rem = W'(r_work - W'(1));
                    n_neg = 1'b0;
                    n_st  = LN_DIV;
                end else if (r_work < -span_w) begin
                    n_rem = W'(-r_work - W'(1));
                    n_neg = 1'b1;
                    n_st  = LN_DIV;
                end else begin
                    n_accum = ST_W'(r_work);
                    n_st    = LN_IDLE;
                end
            end
            LN_DIV: begin
                if (r_rem >= r_dsor) begin
                    n_rem = r_rem - r_dsor;
                    n_q   = {r_q[6:0], 1'b1};
                end else begin
                    n_q   = {r_q[6:0], 1'b0};
                end
                n_dsor = r_dsor >> 1;
                n_cnt  = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_st = LN_DONE;
                end
            end
            LN_DONE: begin
                n_accum = r_neg ? -mag : mag;
                n_color = r_neg ? r_color - r_q : r_color + r_q;
                n_st    = LN_IDLE;
            end
            default: begin
                n_st = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= LN_IDLE;
            r_color <= '0;
            r_goal  <= '0;
            r_delta <= '0;
            r_accum <= '0;
        end else begin
            r_st    <= n_st;
            r_color <= n_color;
            r_goal  <= n_goal;
            r_delta <= n_delta;
            r_accum <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frames <= n_frames;
        r_prod   <= n_prod;
        r_work   <= n_work;
        r_rem    <= n_rem;
        r_dsor   <= n_dsor;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
    end

    assign o_stat.busy  = (r_st != LN_IDLE);
    assign o_stat.color = r_color;

endmodule

`default_nettype wire

[tb/led_color_fade_stepper_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for led_color_fade_stepper_core: directed and random fade sequences, random
// idling on both channels, each result checked against an in-bench fade predictor.
// Depends on lcfs_pkg and led_color_fade_stepper_core.

module led_color_fade_stepper_core_tb;
    import lcfs_pkg::*;

    localparam int QDEPTH      = 8;
    localparam int HOLD_LEN    = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DUE_DEPTH   = 64;
    localparam logic [FRAME_W-1:0] FRAME_TOP = '1;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b1;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;

    int n_sent     = 0;
    int n_checked  = 0;
    int n_rejected = 0;
    int n_errors   = 0;

    t_out_item   due_ring [DUE_DEPTH];
    int unsigned due_wr = 0;
    int unsigned due_rd = 0;

    logic [7:0]         led_rgb [3]               = '{default: 8'd0};
    logic [7:0]         goal_rgb [3]              = '{default: 8'd0};
    logic [7:0]         step_rgb [QDEPTH][3];
    logic [FRAME_W-1:0] step_end [QDEPTH];
    int unsigned        q_head                    = 0;
    int unsigned        q_cnt                     = 0;
    bit                 engine_on                 = 1'b0;
    logic [FRAME_W-1:0] clock_frame               = '0;
    logic [FRAME_W-1:0] stop_frame                = '0;
    logic [31:0]        frame_span                = 32'd1;
    int                 lane_delta [3]            = '{default: 0};
    longint             lane_acc [3]              = '{default: 0};

    led_color_fade_stepper_core #(
        .STEP_QUEUE_DEPTH(QDEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void move_lane(int c, longint frames);
        longint acc, s, k;
        acc = lane_acc[c] + longint'(lane_delta[c]) * frames;
        s   = longint'({32'd0, frame_span});
        if (s < 1) s = 1;
        if (acc > s) begin
            k = (acc - 1) / s;
            acc = acc - k * s;
            led_rgb[c] = led_rgb[c] + k[7:0];
        end else if (acc < -s) begin
            k = (-acc - 1) / s;
            acc = acc + k * s;
            led_rgb[c] = led_rgb[c] - k[7:0];
        end
        lane_acc[c] = acc;
    endfunction

    function automatic void advance_clock(logic [FRAME_W-1:0] target);
        while (engine_on && clock_frame < target) begin
            if (clock_frame < stop_frame) begin
                if (stop_frame > target) begin
                    for (int c = 0; c < 3; c++)
                        move_lane(c, longint'({33'd0, target - clock_frame}));
                    clock_frame = target;
                end else begin
                    for (int c = 0; c < 3; c++) led_rgb[c] = goal_rgb[c];
                    clock_frame = stop_frame;
                end
            end else begin
                if (q_cnt == 0) begin
                    engine_on = 1'b0;
                    break;
                end
                stop_frame = step_end[q_head];
                frame_span = {1'b0, stop_frame} - {1'b0, clock_frame};
                for (int c = 0; c < 3; c++) begin
                    lane_acc[c]   = 0;
                    lane_delta[c] = int'({24'd0, step_rgb[q_head][c]})
                                  - int'({24'd0, led_rgb[c]});
                    goal_rgb[c]   = step_rgb[q_head][c];
                end
                q_head = (q_head + 1) % QDEPTH;
                q_cnt--;
            end
        end
    endfunction

    function automatic t_out_item next_led_state(t_in_item item);
        t_out_item   res;
        logic [7:0]  rgb [3];
        int unsigned slot;
        res    = '0;
        rgb[0] = item.red_in;
        rgb[1] = item.green_in;
        rgb[2] = item.blue_in;
        case (item.opcode)
            OP_QUEUE: begin
                if (!engine_on) begin
                    engine_on   = 1'b1;
                    clock_frame = item.now_frame;
                    stop_frame  = '0;
                    frame_span  = 32'd1;
                    q_head      = 0;
                    q_cnt       = 0;
                    for (int c = 0; c < 3; c++) begin
                        lane_delta[c] = 0;
                        lane_acc[c]   = 0;
                    end
                end
                if (q_cnt >= QDEPTH) begin
                    res.rejected = 1'b1;
                    n_rejected++;
                end else begin
                    slot = (q_head + q_cnt) % QDEPTH;
                    for (int c = 0; c < 3; c++) step_rgb[slot][c] = rgb[c];
                    step_end[slot] = item.frame_in;
                    q_cnt++;
                end
            end
            OP_ADVANCE: advance_clock(item.frame_in);
            default: begin
                engine_on = 1'b0;
                q_head    = 0;
                q_cnt     = 0;
                if (item.opcode == OP_SET)
                    for (int c = 0; c < 3; c++) led_rgb[c] = rgb[c];
            end
        endcase
        res.red_out   = led_rgb[0];
        res.green_out = led_rgb[1];
        res.blue_out  = led_rgb[2];
        res.busy_res  = engine_on;
        return res;
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b, logic [FRAME_W-1:0] frame,
                                          logic [FRAME_W-1:0] now);
        t_in_item item;
        item.opcode    = op;
        item.red_in    = r;
        item.green_in  = g;
        item.blue_in   = b;
        item.frame_in  = frame;
        item.now_frame = now;
        return item;
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 40)
            $display("[%0t] MISMATCH result %0d: %s got 0x%0h want 0x%0h",
                     $time, n_checked, what, got, want);
        n_errors++;
    endtask

    task automatic send_item(input t_in_item item);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        due_ring[due_wr % DUE_DEPTH] = next_led_state(item);
        due_wr++;
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (due_wr != due_rd);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (due_wr == due_rd) begin
                report_mismatch("unexpected result", o_out_item, 0);
            end else begin
                want = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                if (o_out_item.red_out != want.red_out)
                    report_mismatch("red_out", o_out_item.red_out, want.red_out);
                if (o_out_item.green_out != want.green_out)
                    report_mismatch("green_out", o_out_item.green_out, want.green_out);
                if (o_out_item.blue_out != want.blue_out)
                    report_mismatch("blue_out", o_out_item.blue_out, want.blue_out);
                if (o_out_item.busy_res != want.busy_res)
                    report_mismatch("busy_res", o_out_item.busy_res, want.busy_res);
                if (o_out_item.rejected != want.rejected)
                    report_mismatch("rejected", o_out_item.rejected, want.rejected);
            end
            n_checked++;
        end
    end

    initial begin : result_drain
        int pause;
        @(posedge i_clk);
        forever begin
            pause = rx_idle ? $urandom_range(0, 9) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                pause    = HOLD_LEN;
            end
            if (pause > 0) begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic test_directed_cases();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'd100, 31'd0));
        send_item(make_cmd(OP_SET, 8'hFF, 8'h00, 8'hFF, 31'd0, 31'd0));
        send_item(make_cmd(OP_QUEUE, 8'h00, 8'hFF, 8'h80, 31'd10, 31'd0));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'd0, 31'd0));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'd3, 31'd0));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'd10, 31'd0));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'd12, 31'd0));
        for (int k = 0; k <= QDEPTH; k++)
            send_item(make_cmd(OP_QUEUE, 8'(k * 31), 8'(255 - k * 31), 8'(k * 17),
                               (k == 1) ? 31'd55 : FRAME_W'(60 + k * 10), 31'd50));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'd200, 31'd0));
        send_item(make_cmd(OP_QUEUE, 8'hFF, 8'hFF, 8'hFF, FRAME_TOP, 31'd0));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, 31'h4000_0000, 31'd0));
        send_item(make_cmd(OP_SET, 8'h12, 8'h34, 8'h56, FRAME_TOP, FRAME_TOP));
        send_item(make_cmd(OP_QUEUE, 8'h00, 8'h00, 8'h00, 31'd0, FRAME_TOP));
        send_item(make_cmd(OP_ADVANCE, 8'hFF, 8'hFF, 8'hFF, FRAME_TOP, FRAME_TOP));
        send_item(make_cmd(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, FRAME_TOP, FRAME_TOP));
        send_item(make_cmd(OP_QUEUE, 8'h01, 8'h02, 8'h03, FRAME_TOP, 31'd0));
        send_item(make_cmd(OP_ADVANCE, 8'h00, 8'h00, 8'h00, FRAME_TOP, 31'd0));
    endtask

    task automatic test_random_fades(input int n_items);
        int                 stop_at;
        int                 n_steps;
        logic [FRAME_W-1:0] base, last, step_at, tick, reach;
        logic [95:0]        noise;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0) begin
                noise = {$urandom, $urandom, $urandom};
                send_item(noise[$bits(t_in_item)-1:0]);
            end else begin
                base = ($urandom_range(0, 4) == 0) ? FRAME_W'($urandom)
                                                   : FRAME_W'($urandom_range(0, 3000));
                send_item(make_cmd($urandom_range(0, 1) ? OP_SET : OP_CLEAR, rand8(),
                                   rand8(), rand8(), FRAME_W'($urandom), FRAME_W'($urandom)));
                n_steps = $urandom_range(1, QDEPTH + 2);
                last = base;
                tick = base;
                for (int k = 0; k < n_steps; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        step_at = last - FRAME_W'($urandom_range(0, 4));
                    end else begin
                        last = last + FRAME_W'(($urandom_range(0, 9) == 0)
                                               ? $urandom_range(41, 4000)
                                               : $urandom_range(1, 40));
                        step_at = last;
                    end
                    send_item(make_cmd(OP_QUEUE, rand8(), rand8(), rand8(), step_at, base));
                    if ($urandom_range(0, 3) == 0) begin
                        tick = tick + FRAME_W'($urandom_range(0, 12));
                        send_item(make_cmd(OP_ADVANCE, rand8(), rand8(), rand8(), tick,
                                           FRAME_W'($urandom)));
                    end
                end
                reach = last - base + 3;
                while (tick - base < reach) begin
                    tick = tick + FRAME_W'($urandom_range(0, reach / 5 + 2));
                    send_item(make_cmd(OP_ADVANCE, rand8(), rand8(), rand8(), tick,
                                       FRAME_W'($urandom)));
                end
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end
    endtask

    task automatic test_output_backpressure();
        logic [FRAME_W-1:0] t0;
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        t0       = FRAME_W'($urandom_range(0, 100000));
        hold_req = 1'b1;
        send_item(make_cmd(OP_SET, rand8(), rand8(), rand8(), 31'd0, 31'd0));
        for (int k = 0; k < QDEPTH + 2; k++)
            send_item(make_cmd(OP_QUEUE, rand8(), rand8(), rand8(),
                               t0 + FRAME_W'(7 * (k + 1)), t0));
        for (int k = 1; k <= 16; k++)
            send_item(make_cmd(OP_ADVANCE, rand8(), rand8(), rand8(),
                               t0 + FRAME_W'(5 * k), t0));
        wait_drained();
    endtask

    task automatic test_sender_pause();
        logic [FRAME_W-1:0] t0;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        t0      = FRAME_W'($urandom_range(0, 5000));
        send_item(make_cmd(OP_CLEAR, rand8(), rand8(), rand8(), 31'd0, 31'd0));
        for (int k = 0; k < 4; k++)
            send_item(make_cmd(OP_QUEUE, rand8(), rand8(), rand8(),
                               t0 + FRAME_W'(20 * (k + 1)), t0));
        wait_drained();
        for (int k = 1; k <= 8; k++)
            send_item(make_cmd(OP_ADVANCE, rand8(), rand8(), rand8(),
                               t0 + FRAME_W'(11 * k), t0));
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_fades(720);
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Covered directed fades, random fade sequences with noise items, a long");
        $display("output hold-off and a sender pause: %0d items, %0d results, %0d rejects,",
                 n_sent, n_checked, n_rejected);
        $display("%0d errors", n_errors);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
